>>> design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types, sizes and codes shared by the slot table stack with first-free reuse.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Slot index width is fixed by the request and result formats.
  localparam int IDX_W       = 8;
  localparam int TABLE_DEPTH = 1 << IDX_W;
  localparam int DATA_BITS   = 32;
  localparam int TAG_BITS    = 16;
  localparam int KIND_W      = 4;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;

  // First-free search: groups of GRP_W slots, picked in two steps with a register between.
  localparam int GRP_W       = 16;
  localparam int GRP_N       = TABLE_DEPTH / GRP_W;
  localparam int GRP_IDX_W   = $clog2(GRP_N);
  localparam int OFF_W       = $clog2(GRP_W);

  localparam logic [KIND_W-1:0] KIND_EMPTY = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_VOID  = KIND_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_SET    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [IDX_W-1:0]     slot_index;
    logic [DATA_BITS-1:0] entry_data;
    logic [KIND_W-1:0]    entry_kind;
    logic [TAG_BITS-1:0]  entry_tag;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]     result_index;
    logic [DATA_BITS-1:0] result_data;
    logic [KIND_W-1:0]    result_kind;
    logic [TAG_BITS-1:0]  result_tag;
    logic [STATUS_W-1:0]  status;
  } res_t;

  // Write request into the slot store.
  typedef struct packed {
    logic                 kind_we;
    logic                 dt_we;
    logic [IDX_W-1:0]     addr;
    logic [KIND_W-1:0]    kind;
    logic [DATA_BITS-1:0] data;
    logic [TAG_BITS-1:0]  tag;
  } sts_wr_t;

  // Registered read data from the slot store.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [DATA_BITS-1:0] data;
    logic [TAG_BITS-1:0]  tag;
  } sts_rd_t;

  // Outcome of the first-free search.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] slot;
  } sts_find_t;

endpackage

>>> design/sts_store.sv
// ----------------------------------------------------------------------------
// sts_store
// Slot memories (kind, data and tag) with registered read, plus
// per-slot written and empty flags kept in flops.
// ----------------------------------------------------------------------------
module sts_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [sts_pkg::IDX_W-1:0]         rd_addr,
  input  sts_pkg::sts_wr_t                  wr,
  output logic [sts_pkg::TABLE_DEPTH-1:0]   empty_o,
  output sts_pkg::sts_rd_t                  rd
);

  localparam int DT_W = sts_pkg::DATA_BITS + sts_pkg::TAG_BITS;

  logic [sts_pkg::KIND_W-1:0] kind_mem [sts_pkg::TABLE_DEPTH];
  logic [DT_W-1:0]            dt_mem   [sts_pkg::TABLE_DEPTH];

  logic [sts_pkg::TABLE_DEPTH-1:0] kind_wr_r;
  logic [sts_pkg::TABLE_DEPTH-1:0] empty_r;

  logic [sts_pkg::KIND_W-1:0] kind_q_r;
  logic [DT_W-1:0]            dt_q_r;
  logic                       kind_ok_r;
  logic                       addr_zero_r;

  always_ff @(posedge clk) begin
    if (wr.kind_we) begin
      kind_mem[wr.addr] <= wr.kind;
    end
    if (rd_en) begin
      kind_q_r <= kind_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.dt_we) begin
      dt_mem[wr.addr] <= {wr.data, wr.tag};
    end
    if (rd_en) begin
      dt_q_r <= dt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      kind_ok_r   <= kind_wr_r[rd_addr];
      addr_zero_r <= (rd_addr == '0);
    end
  end

  // Slot zero starts void, every other slot empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_wr_r <= '0;
      empty_r   <= {{(sts_pkg::TABLE_DEPTH-1){1'b1}}, 1'b0};
    end else if (wr.kind_we) begin
      kind_wr_r[wr.addr] <= 1'b1;
      empty_r[wr.addr]   <= (wr.kind == sts_pkg::KIND_EMPTY);
    end
  end

  always_comb begin
    rd.data = dt_q_r[DT_W-1:sts_pkg::TAG_BITS];
    rd.tag  = dt_q_r[sts_pkg::TAG_BITS-1:0];
    if (kind_ok_r) begin
      rd.kind = kind_q_r;
    end else begin
      rd.kind = addr_zero_r ? sts_pkg::KIND_VOID : sts_pkg::KIND_EMPTY;
    end
  end

  assign empty_o = empty_r;

endmodule

>>> design/sts_search.sv
// ----------------------------------------------------------------------------
// sts_search
// Lowest empty slot in 1..top-1, found in two steps with a register between: pick the
// lowest group holding a candidate, then the lowest slot inside it.
// ----------------------------------------------------------------------------
module sts_search (
  input  logic                            clk,
  input  logic                            load,
  input  logic [sts_pkg::IDX_W-1:0]       top,
  input  logic [sts_pkg::TABLE_DEPTH-1:0] empty,
  output sts_pkg::sts_find_t              find
);

  logic [sts_pkg::TABLE_DEPTH-1:0] cand;
  logic [sts_pkg::GRP_N-1:0]       grp_any;
  logic                            grp_hit;
  logic [sts_pkg::GRP_IDX_W-1:0]   grp_sel;
  logic [sts_pkg::GRP_W-1:0]       grp_bits;

  logic                            grp_hit_r;
  logic [sts_pkg::GRP_IDX_W-1:0]   grp_sel_r;
  logic [sts_pkg::GRP_W-1:0]       grp_bits_r;

  logic [sts_pkg::OFF_W-1:0]       off;

  always_comb begin
    for (int i = 0; i < sts_pkg::TABLE_DEPTH; i++) begin
      cand[i] = empty[i] && (i != 0) && (sts_pkg::IDX_W'(i) < top);
    end
    for (int g = 0; g < sts_pkg::GRP_N; g++) begin
      grp_any[g] = |cand[g*sts_pkg::GRP_W +: sts_pkg::GRP_W];
    end
    grp_hit = 1'b0;
    grp_sel = '0;
    // Scan downwards so the lowest group wins.
    for (int g = sts_pkg::GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_hit = 1'b1;
        grp_sel = sts_pkg::GRP_IDX_W'(g);
      end
    end
    grp_bits = cand[grp_sel*sts_pkg::GRP_W +: sts_pkg::GRP_W];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_hit_r  <= grp_hit;
      grp_sel_r  <= grp_sel;
      grp_bits_r <= grp_bits;
    end
  end

  always_comb begin
    off = '0;
    for (int k = sts_pkg::GRP_W - 1; k >= 0; k--) begin
      if (grp_bits_r[k]) begin
        off = sts_pkg::OFF_W'(k);
      end
    end
    find.hit  = grp_hit_r;
    find.slot = {grp_sel_r, off};
  end

endmodule

>>> design/slot_table_stack_first_free_top.sv
// ----------------------------------------------------------------------------
// slot_table_stack_first_free_top
// Slot table run as a stack with reuse of empty slots below the top.
// An item is accepted only in the idle state; its result is registered in the
// execute state, from which the receiver can take it. No new item is taken
// until the slot memory read-modify-write is done (read at acceptance,
// write back in the execute cycle). A stalled result holds the next item.
// Reset (synchronous, active low): top at 0, slot 0 void, all others empty,
// no result pending; no clearing pass, items are taken straight away.
// ----------------------------------------------------------------------------
module slot_table_stack_first_free_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sts_pkg::req_t in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output sts_pkg::res_t out_item
);

  sts_pkg::state_t  state_r, state_nxt;
  sts_pkg::req_t    req_r;
  sts_pkg::res_t    out_r, res;
  logic             out_valid_r, out_valid_nxt;
  logic [sts_pkg::IDX_W-1:0] top_r, top_nxt;

  logic             accept;
  logic             fire;
  logic [sts_pkg::IDX_W-1:0] rd_addr;
  sts_pkg::sts_wr_t wr, wr_raw;
  sts_pkg::sts_rd_t rd;
  sts_pkg::sts_find_t find;
  logic [sts_pkg::TABLE_DEPTH-1:0] empty;

  logic             full;
  logic             idx_in_table;
  logic             idx_beyond_top;
  logic [sts_pkg::IDX_W-1:0] top_p1;

  assign in_stall = (state_r != sts_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = (in_item.cmd == sts_pkg::CMD_POP) ? top_r : in_item.slot_index;

  // Execute only once the result register can take the item.
  assign fire = (state_r == sts_pkg::S_EXEC) && (!out_valid_r || !out_stall);

  sts_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (wr),
    .empty_o (empty),
    .rd      (rd)
  );

  sts_search u_search (
    .clk   (clk),
    .load  (accept),
    .top   (top_r),
    .empty (empty),
    .find  (find)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sts_pkg::S_IDLE: begin
        if (accept) state_nxt = sts_pkg::S_EXEC;
      end
      sts_pkg::S_EXEC: begin
        if (fire) state_nxt = sts_pkg::S_IDLE;
      end
      default: state_nxt = sts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
  end

  always_comb begin
    full           = ({2'b00, top_r} + (sts_pkg::IDX_W+2)'(2)) >
                     (sts_pkg::IDX_W+2)'(sts_pkg::TABLE_DEPTH);
    idx_in_table   = ({1'b0, req_r.slot_index} < (sts_pkg::IDX_W+1)'(sts_pkg::TABLE_DEPTH));
    idx_beyond_top = (req_r.slot_index > top_r);
    top_p1         = top_r + sts_pkg::IDX_W'(1);

    res     = '0;
    res.status = sts_pkg::ST_OK;
    wr_raw  = '0;
    wr_raw.data = req_r.entry_data;
    wr_raw.kind = req_r.entry_kind;
    wr_raw.tag  = req_r.entry_tag;
    top_nxt = top_r;

    case (req_r.cmd)
      sts_pkg::CMD_PUSH, sts_pkg::CMD_INSERT: begin
        if (req_r.cmd == sts_pkg::CMD_INSERT && find.hit) begin
          wr_raw.kind_we   = 1'b1;
          wr_raw.dt_we     = 1'b1;
          wr_raw.addr      = find.slot;
          res.result_index = find.slot;
        end else if (full) begin
          res.status = sts_pkg::ST_FULL;
        end else begin
          wr_raw.kind_we   = 1'b1;
          wr_raw.dt_we     = 1'b1;
          wr_raw.addr      = top_p1;
          res.result_index = top_p1;
          top_nxt          = top_p1;
        end
      end
      sts_pkg::CMD_POP: begin
        if (top_r == '0) begin
          res.status = sts_pkg::ST_POP_EMPTY;
        end else begin
          res.result_index = top_r;
          res.result_data  = rd.data;
          res.result_kind  = rd.kind;
          res.result_tag   = rd.tag;
          wr_raw.kind_we   = 1'b1;
          wr_raw.addr      = top_r;
          wr_raw.kind      = sts_pkg::KIND_EMPTY;
          top_nxt          = top_r - sts_pkg::IDX_W'(1);
        end
      end
      sts_pkg::CMD_REMOVE: begin
        if (!idx_in_table) begin
          res.status = sts_pkg::ST_RANGE;
        end else begin
          wr_raw.kind_we   = 1'b1;
          wr_raw.addr      = req_r.slot_index;
          wr_raw.kind      = sts_pkg::KIND_EMPTY;
          res.result_index = req_r.slot_index;
        end
      end
      sts_pkg::CMD_GET: begin
        if (idx_beyond_top) begin
          res.status = sts_pkg::ST_RANGE;
        end else begin
          res.result_index = req_r.slot_index;
          res.result_data  = rd.data;
          res.result_kind  = rd.kind;
          res.result_tag   = rd.tag;
        end
      end
      sts_pkg::CMD_SET: begin
        if (idx_beyond_top) begin
          res.status = sts_pkg::ST_RANGE;
        end else begin
          wr_raw.kind_we   = 1'b1;
          wr_raw.dt_we     = 1'b1;
          wr_raw.addr      = req_r.slot_index;
          res.result_index = req_r.slot_index;
        end
      end
      default: begin
        // Unused command: drop, answer all zero.
      end
    endcase

    wr         = wr_raw;
    wr.kind_we = wr_raw.kind_we && fire;
    wr.dt_we   = wr_raw.dt_we && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else if (fire) begin
      top_r <= top_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A new result appears only from the execute cycle.
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sts_pkg::S_EXEC))
    else $error("result raised without an executing item");

  // Slot memories change only while an item executes into a free result register.
  a_write_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.kind_we || wr.dt_we) |-> (state_r == sts_pkg::S_EXEC) && (!out_valid_r || !out_stall))
    else $error("slot write outside execute");

  // The top pointer moves by one slot at most per item.
  a_top_step: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r != $past(top_r)) |->
      (top_r == $past(top_r) + sts_pkg::IDX_W'(1)) ||
      (top_r == $past(top_r) - sts_pkg::IDX_W'(1)))
    else $error("top pointer jumped");

endmodule
